@@ hw/rtl/hdr_pkg.sv @@
// Package for the two-exposure HDR pixel merge unit.
// Widths, register indexes, lane item types and shared constants; no dependencies.
package hdr_pkg;

    localparam int CHANNELS_DEF    = 3;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int GAIN_BITS       = 24;
    localparam int SAT_BITS        = 17;
    localparam int UNDER_BITS      = 16;
    localparam int FLOOR_BITS      = 16;
    localparam int OUT_BITS        = 24;
    localparam int W_BITS          = 17;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 24;

    // Q1.16 weight scale: 1.0 is 65536.
    localparam logic [W_BITS-1:0] W_ONE = 17'h10000;

    localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_GAIN = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAT_THR    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNDER_THR  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR      = 3'd4;

    // Divider width for a 17-bit quotient, one quotient bit per divider cell.
    localparam int DIV_BITS = 34;

    // Register values held by the configuration register of the top level.
    typedef struct packed {
        logic [GAIN_BITS-1:0]  short_gain;
        logic [GAIN_BITS-1:0]  long_gain;
        logic [SAT_BITS-1:0]   sat_threshold;
        logic [UNDER_BITS-1:0] under_threshold;
        logic [FLOOR_BITS-1:0] weight_floor;
    } hdr_cfg_t;

endpackage

@@ hw/rtl/hdr_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit per cycle while adv is high.
// Uses no package; instantiated as a chain by hdr_div_chain.
module hdr_div_cell #(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 64,
    parameter int Q_BITS   = 24,
    parameter int SIDE_BITS = 1,
    parameter int STEP     = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [NUM_BITS-1:0]  in_rem,
    input  logic [DEN_BITS-1:0]  in_den,
    input  logic [Q_BITS-1:0]    in_quo,
    input  logic [SIDE_BITS-1:0] in_side,
    output logic                 out_valid,
    output logic [NUM_BITS-1:0]  out_rem,
    output logic [DEN_BITS-1:0]  out_den,
    output logic [Q_BITS-1:0]    out_quo,
    output logic [SIDE_BITS-1:0] out_side
);

    localparam int SH = Q_BITS - 1 - STEP;

    logic                 valid_reg;
    logic [NUM_BITS-1:0]  rem_reg, rem_next;
    logic [DEN_BITS-1:0]  den_reg;
    logic [Q_BITS-1:0]    quo_reg, quo_next;
    logic [SIDE_BITS-1:0] side_reg;
    logic [NUM_BITS+Q_BITS-1:0] trial;
    logic                 fits;

    always_comb
    begin
        trial    = {{Q_BITS{1'b0}}, NUM_BITS'(in_den)} << SH;
        fits     = {{Q_BITS{1'b0}}, in_rem} >= trial;
        rem_next = fits ? in_rem - NUM_BITS'(trial) : in_rem;
        quo_next = in_quo;
        quo_next[SH] = fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

@@ hw/rtl/hdr_div_chain.sv @@
// Chain of hdr_div_cell: one quotient bit per cell, Q_BITS cells, fully pipelined.
// Uses no package; quotient saturation is left to the caller.
module hdr_div_chain #(
    parameter int NUM_BITS  = 64,
    parameter int DEN_BITS  = 64,
    parameter int Q_BITS    = 24,
    parameter int SIDE_BITS = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [NUM_BITS-1:0]  in_num,
    input  logic [DEN_BITS-1:0]  in_den,
    input  logic [SIDE_BITS-1:0] in_side,
    output logic                 out_valid,
    output logic [Q_BITS-1:0]    out_quo,
    output logic                 out_over,
    output logic [SIDE_BITS-1:0] out_side
);

    logic                 v   [Q_BITS+1];
    logic [NUM_BITS-1:0]  rem [Q_BITS+1];
    logic [DEN_BITS-1:0]  den [Q_BITS+1];
    logic [Q_BITS-1:0]    quo [Q_BITS+1];
    logic [SIDE_BITS-1:0] sd  [Q_BITS+1];

    assign v[0]   = in_valid;
    assign rem[0] = in_num;
    assign den[0] = in_den;
    assign quo[0] = '0;
    assign sd[0]  = in_side;

    genvar i;
    generate
        for (i = 0; i < Q_BITS; i++)
        begin : g_cell
            hdr_div_cell #(
                .NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS), .Q_BITS(Q_BITS),
                .SIDE_BITS(SIDE_BITS), .STEP(i)
            ) u_cell (
                .clk(clk), .rst_n(rst_n), .adv(adv),
                .in_valid(v[i]), .in_rem(rem[i]), .in_den(den[i]),
                .in_quo(quo[i]), .in_side(sd[i]),
                .out_valid(v[i+1]), .out_rem(rem[i+1]), .out_den(den[i+1]),
                .out_quo(quo[i+1]), .out_side(sd[i+1])
            );
        end
    endgenerate

    // Remainder still at or above the divisor means the true quotient overflowed.
    assign out_valid = v[Q_BITS];
    assign out_quo   = quo[Q_BITS];
    assign out_over  = {{DEN_BITS{1'b0}}, rem[Q_BITS]} >= {{NUM_BITS{1'b0}}, den[Q_BITS]};
    assign out_side  = sd[Q_BITS];

endmodule

@@ hw/rtl/two_exposure_hdr_pixel_merge_unit.sv @@
// Top level of the two-exposure HDR pixel merge unit.
// Uses hdr_pkg, hdr_div_chain and hdr_div_cell.
//
// channel | dir | handshake          | payload
// s_axis  | in  | tvalid/tready      | tdata: short r,g,b then long r,g,b
// m_axis  | out | tvalid/tready      | tdata: merged r,g,b; tuser: config_invalid
// cfg     | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// One item per cycle while the pipe advances; stages: peak register, weight divider chain,
// one radiance multiply stage, weighted-sum register, output divider chain, output register.
// The whole pipe advances when the output register is empty or being taken.
// Reset clears the valid bits and loads the register reset values.
module two_exposure_hdr_pixel_merge_unit #(
    parameter int CHANNELS    = hdr_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = hdr_pkg::SAMPLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // short ch0..ch(C-1), then long ch0..ch(C-1), SAMPLE_BITS each
    input  logic [((2*CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // merged ch0..ch(C-1), 24 bits each
    output logic [CHANNELS*hdr_pkg::OUT_BITS-1:0] m_axis_tdata,
    // config_invalid
    output logic m_axis_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [hdr_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [hdr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int OB   = hdr_pkg::OUT_BITS;
    localparam int GB   = hdr_pkg::GAIN_BITS;
    localparam int WB   = hdr_pkg::W_BITS;
    localparam int RB   = SB + GB - (SB - 8);      // radiance width
    localparam int NB   = RB + WB + 1;              // weighted sum width
    localparam int DB   = WB + 2 + 8;               // denominator width
    localparam int WNB  = SB + 17;                   // weight numerator width
    localparam int WDB  = SB + 1;
    localparam int SIDE = 2*CHANNELS*SB + 2;
    localparam logic [SB:0] ONE_S = (SB+1)'(1) << SB;

    // ---------------- configuration
    hdr_pkg::hdr_cfg_t cfg_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_gain      <= 24'd65536;
            cfg_reg.long_gain       <= 24'd65536;
            cfg_reg.sat_threshold   <= 17'd62259;
            cfg_reg.under_threshold <= 16'd3277;
            cfg_reg.weight_floor    <= 16'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hdr_pkg::REG_SHORT_GAIN: cfg_reg.short_gain <= cfg_data;
                hdr_pkg::REG_LONG_GAIN:  cfg_reg.long_gain  <= cfg_data;
                hdr_pkg::REG_SAT_THR:    cfg_reg.sat_threshold <= cfg_data[16:0];
                hdr_pkg::REG_UNDER_THR:  cfg_reg.under_threshold <= cfg_data[15:0];
                hdr_pkg::REG_FLOOR:      cfg_reg.weight_floor <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [SB:0] sat_x, under_x;
    logic        bad;
    always_comb
    begin
        sat_x   = (SB+1)'(cfg_reg.sat_threshold);
        under_x = (SB+1)'(cfg_reg.under_threshold);
        bad = cfg_reg.short_gain == '0 || cfg_reg.long_gain == '0 ||
              cfg_reg.sat_threshold == '0 ||
              {15'd0, cfg_reg.sat_threshold} > 32'(ONE_S) ||
              {16'd0, cfg_reg.under_threshold} >= 32'(ONE_S) ||
              cfg_reg.weight_floor == '0;
    end

    // ---------------- pipe control
    logic out_valid_reg;
    logic adv;
    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- stage 1: peaks and ramp setup
    logic [SB-1:0] smp [2*CHANNELS];
    logic [SB-1:0] pk_s, pk_l;
    always_comb
    begin
        for (int k = 0; k < 2*CHANNELS; k++)
            smp[k] = s_axis_tdata[k*SB +: SB];
        pk_s = smp[0];
        pk_l = smp[CHANNELS];
        for (int c = 1; c < CHANNELS; c++)
        begin
            if (smp[c] > pk_s) pk_s = smp[c];
            if (smp[CHANNELS+c] > pk_l) pk_l = smp[CHANNELS+c];
        end
    end

    logic              s1_valid_reg;
    logic [WNB-1:0]    s1_numS_reg, s1_numL_reg;
    logic [WDB-1:0]    s1_denS_reg, s1_denL_reg;
    logic              s1_fullS_reg, s1_fullL_reg;
    logic [2*CHANNELS*SB-1:0] s1_smp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_fullS_reg <= (SB+1)'(pk_s) >= under_x;
            s1_fullL_reg <= (SB+1)'(pk_l) <= sat_x;
            s1_numS_reg  <= WNB'(pk_s) << 16;
            s1_denS_reg  <= (under_x == '0) ? WDB'(1) : under_x;
            s1_numL_reg  <= WNB'(ONE_S - (SB+1)'(pk_l)) << 16;
            s1_denL_reg  <= ((SB+1)'(pk_l) <= sat_x) ? WDB'(1) : ONE_S - sat_x;
            s1_smp_reg   <= s_axis_tdata[2*CHANNELS*SB-1:0];
        end
    end

    // ---------------- weight dividers (17-bit quotients)
    logic          wdS_valid, wdL_valid, wdS_over, wdL_over;
    logic [WB-1:0] wdS_quo, wdL_quo;
    logic [SIDE-1:0] wd_side, wdL_side;

    hdr_div_chain #(.NUM_BITS(WNB), .DEN_BITS(WDB), .Q_BITS(WB), .SIDE_BITS(SIDE))
    u_wdiv_s (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(s1_valid_reg),
        .in_num(s1_numS_reg), .in_den(s1_denS_reg),
        .in_side({s1_fullS_reg, s1_fullL_reg, s1_smp_reg}),
        .out_valid(wdS_valid), .out_quo(wdS_quo), .out_over(wdS_over),
        .out_side(wd_side)
    );

    hdr_div_chain #(.NUM_BITS(WNB), .DEN_BITS(WDB), .Q_BITS(WB), .SIDE_BITS(SIDE))
    u_wdiv_l (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(s1_valid_reg),
        .in_num(s1_numL_reg), .in_den(s1_denL_reg), .in_side(SIDE'(0)),
        .out_valid(wdL_valid), .out_quo(wdL_quo), .out_over(wdL_over),
        .out_side(wdL_side)
    );

    logic [WB-1:0] ws, wl;
    logic          fullS, fullL;
    always_comb
    begin
        fullS = wd_side[SIDE-1];
        fullL = wd_side[SIDE-2];
        ws = (fullS || wdS_over || wdS_quo > hdr_pkg::W_ONE) ? hdr_pkg::W_ONE : wdS_quo;
        wl = (fullL || wdL_over || wdL_quo > hdr_pkg::W_ONE) ? hdr_pkg::W_ONE : wdL_quo;
    end

    // ---------------- stage 2: radiance products (registered)
    logic [RB-1:0] rad_s_reg [CHANNELS];
    logic [RB-1:0] rad_l_reg [CHANNELS];
    logic [WB-1:0] ws_reg, wl_reg;
    logic          m_valid_reg;
    logic [DB-1:0] den_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (adv)
            m_valid_reg <= wdS_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ws_reg <= ws;
            wl_reg <= wl;
            for (int c = 0; c < CHANNELS; c++)
            begin
                rad_s_reg[c] <= RB'(((SB+GB)'(wd_side[c*SB +: SB]) *
                                     (SB+GB)'(cfg_reg.short_gain)) >> (SB - 8));
                rad_l_reg[c] <= RB'(((SB+GB)'(wd_side[(CHANNELS+c)*SB +: SB]) *
                                     (SB+GB)'(cfg_reg.long_gain)) >> (SB - 8));
            end
        end
    end

    assign den_w = DB'({(WB+2)'(ws_reg) + (WB+2)'(wl_reg) +
                        (WB+2)'(cfg_reg.weight_floor), 8'd0});

    // ---------------- stage 3: weighted sums (registered), then output division
    logic [NB-1:0] num_reg [CHANNELS];
    logic [DB-1:0] den_reg;
    logic          n_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_valid_reg <= 1'b0;
        else if (adv)
            n_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg <= den_w;
            for (int c = 0; c < CHANNELS; c++)
                num_reg[c] <= NB'(NB'(ws_reg) * NB'(rad_s_reg[c])) +
                              NB'(NB'(wl_reg) * NB'(rad_l_reg[c]));
        end
    end

    logic          od_valid [CHANNELS];
    logic [OB-1:0] od_quo   [CHANNELS];
    logic          od_over  [CHANNELS];
    logic          od_side  [CHANNELS];

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++)
        begin : g_odiv
            hdr_div_chain #(.NUM_BITS(NB), .DEN_BITS(DB), .Q_BITS(OB), .SIDE_BITS(1))
            u_odiv (
                .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(n_valid_reg),
                .in_num(num_reg[g]), .in_den(den_reg), .in_side(1'b0),
                .out_valid(od_valid[g]), .out_quo(od_quo[g]), .out_over(od_over[g]),
                .out_side(od_side[g])
            );
        end
    endgenerate

    // ---------------- output register
    logic [CHANNELS*OB-1:0] out_data_reg;
    logic                   out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= od_valid[0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_user_reg <= bad;
            for (int c = 0; c < CHANNELS; c++)
                out_data_reg[c*OB +: OB] <= (bad || od_side[c]) ? '0 :
                                            (od_over[c] ? '1 : od_quo[c]);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("result lost under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_wsum: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> ws_reg <= hdr_pkg::W_ONE && wl_reg <= hdr_pkg::W_ONE)
        else $error("weight above one");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for two_exposure_hdr_pixel_merge_unit.
// Drives random pixel pairs and register writes, predicts each merged pixel; uses hdr_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int NCH    = 3;
    localparam int SBITS  = 16;
    localparam int IN_W   = ((2*NCH*SBITS+7)/8)*8;
    localparam int OUT_W  = NCH*hdr_pkg::OUT_BITS;
    localparam int LAT    = 50;
    localparam int LIMIT  = 400000;

    typedef struct packed {
        logic [15:0] lb, lg, lr, sb, sg, sr;
    } pair_t;

    typedef struct packed {
        logic        bad;
        logic [23:0] b, g, r;
    } merged_t;

    logic clk, rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_valid, cfg_ready;
    logic [hdr_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [hdr_pkg::CFG_DATA_BITS-1:0] cfg_data;

    two_exposure_hdr_pixel_merge_unit dut (.*);

    hdr_pkg::hdr_cfg_t regs;
    pair_t    pixel_q[$];
    merged_t  merged_q[$];
    int       errors, cycles, in_gap, out_gap;
    bit       hold, in_acc, out_acc;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic logic [16:0] peak3(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        logic [15:0] m;
        m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        return {1'b0, m};
    endfunction

    function automatic merged_t merge_pixel(pair_t p);
        merged_t o;
        logic [63:0] ws, wl, den, ms, ml, q;
        logic [15:0] sv[3], lv[3];
        sv = '{p.sr, p.sg, p.sb};
        lv = '{p.lr, p.lg, p.lb};
        o = '0;
        if (regs.short_gain == 0 || regs.long_gain == 0 || regs.sat_threshold == 0 ||
            regs.sat_threshold > 17'h10000 || regs.weight_floor == 0)
        begin
            o.bad = 1'b1;
            return o;
        end
        ms = peak3(p.sr, p.sg, p.sb);
        ml = peak3(p.lr, p.lg, p.lb);
        if (ms >= regs.under_threshold) ws = 65536;
        else ws = (ms * 65536) / regs.under_threshold;
        if (ws > 65536) ws = 65536;
        if (ml <= regs.sat_threshold) wl = 65536;
        else wl = ((65536 - ml) * 65536) / (65536 - regs.sat_threshold);
        if (wl > 65536) wl = 65536;
        den = (ws + wl + regs.weight_floor) << 8;
        for (int c = 0; c < 3; c++)
        begin
            q = (ws * ((64'(sv[c]) * regs.short_gain) >> 8) +
                 wl * ((64'(lv[c]) * regs.long_gain) >> 8)) / den;
            if (q > 64'hFFFFFF) q = 64'hFFFFFF;
            case (c)
                0: o.r = q[23:0];
                1: o.g = q[23:0];
                default: o.b = q[23:0];
            endcase
        end
        return o;
    endfunction

    task automatic write_reg(logic [hdr_pkg::CFG_IDX_BITS-1:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            hdr_pkg::REG_SHORT_GAIN: regs.short_gain      = val;
            hdr_pkg::REG_LONG_GAIN:  regs.long_gain       = val;
            hdr_pkg::REG_SAT_THR:    regs.sat_threshold   = val[16:0];
            hdr_pkg::REG_UNDER_THR:  regs.under_threshold = val[15:0];
            hdr_pkg::REG_FLOOR:      regs.weight_floor    = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pixel_q.size() != 0 || merged_q.size() != 0) @(posedge clk);
        repeat (LAT) @(posedge clk);
    endtask

    function automatic logic [15:0] rnd_sample;
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 4000));
            3: return 16'($urandom_range(60000, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pair_t rnd_pair;
        pair_t p;
        p.sr = rnd_sample(); p.sg = rnd_sample(); p.sb = rnd_sample();
        p.lr = rnd_sample(); p.lg = rnd_sample(); p.lb = rnd_sample();
        return p;
    endfunction

    task automatic burst(int n);
        for (int i = 0; i < n; i++) pixel_q.push_back(rnd_pair());
    endtask

    // handshakes as seen at the rising edge
    always @(posedge clk)
    begin
        in_acc  = rst_n && s_axis_tvalid && s_axis_tready;
        out_acc = rst_n && m_axis_tvalid && m_axis_tready;
        if (in_acc)
            merged_q.push_back(merge_pixel(pixel_q.pop_front()));
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_acc)
                in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            if (in_gap > 0) in_gap--;
            if (!s_axis_tvalid || in_acc)
            begin
                if (!hold && in_gap == 0 && pixel_q.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_W'(pixel_q[0]);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            if (out_acc)
                out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            if (out_gap > 0) out_gap--;
            m_axis_tready <= (out_gap == 0);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            merged_t got, want;
            got = {m_axis_tuser, m_axis_tdata};
            if (merged_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected item %h", got);
            end
            else
            begin
                want = merged_q.pop_front();
                if (got.r !== want.r || got.g !== want.g || got.b !== want.b ||
                    got.bad !== want.bad)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp r%h g%h b%h inv%b, got r%h g%h b%h inv%b",
                                 want.r, want.g, want.b, want.bad,
                                 got.r, got.g, got.b, got.bad);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        pair_t p;
        errors = 0; cycles = 0; in_gap = 0; out_gap = 0; hold = 0;
        in_acc = 0; out_acc = 0;
        rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        regs = '{short_gain: 24'd65536, long_gain: 24'd65536, sat_threshold: 17'd62259,
                 under_threshold: 16'd3277, weight_floor: 16'd1};
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1;

        // directed: extremes, knees
        pixel_q.push_back('0);
        pixel_q.push_back('1);
        p = '0; p.sr = 16'd3277; p.lr = 16'd62259; pixel_q.push_back(p);
        p = '0; p.sg = 16'd3276; p.lb = 16'd62260; pixel_q.push_back(p);
        p = '0; p.sb = 16'd1; p.lr = 16'hFFFF; pixel_q.push_back(p);
        p = '1; p.sr = 16'h5555; p.lg = 16'hAAAA; pixel_q.push_back(p);
        p = {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};
        pixel_q.push_back(p);
        burst(8);
        drain();

        write_reg(hdr_pkg::REG_SHORT_GAIN, 24'hFFFFFF);
        write_reg(hdr_pkg::REG_LONG_GAIN, 24'd1);
        write_reg(hdr_pkg::REG_SAT_THR, 24'd65536);
        write_reg(hdr_pkg::REG_UNDER_THR, 24'd0);
        write_reg(hdr_pkg::REG_FLOOR, 24'hFFFF);
        pixel_q.push_back('1); pixel_q.push_back('0);
        burst(120);
        drain();

        // invalid settings
        write_reg(hdr_pkg::REG_FLOOR, 24'd0);
        burst(10);
        drain();
        write_reg(hdr_pkg::REG_FLOOR, 24'd1);
        write_reg(hdr_pkg::REG_SAT_THR, 24'd0);
        burst(5);
        drain();
        write_reg(hdr_pkg::REG_SAT_THR, 24'h1FFFF);
        burst(5);
        drain();
        write_reg(hdr_pkg::REG_SAT_THR, 24'd1);
        write_reg(hdr_pkg::REG_SHORT_GAIN, 24'd0);
        burst(5);
        drain();
        write_reg(3'd7, 24'h123456);

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(hdr_pkg::REG_SHORT_GAIN, 24'($urandom_range(1, 24'hFFFFFF)));
            write_reg(hdr_pkg::REG_LONG_GAIN, 24'($urandom_range(1, 24'h3FFFF)));
            write_reg(hdr_pkg::REG_SAT_THR, 24'($urandom_range(1, 65536)));
            write_reg(hdr_pkg::REG_UNDER_THR, 24'($urandom_range(0, 65535)));
            write_reg(hdr_pkg::REG_FLOOR, 24'($urandom_range(1, 65535)));
            burst(60);
            while (pixel_q.size() > 30) @(posedge clk);
            hold = 1;
            while (merged_q.size() != 0) @(posedge clk);
            hold = 0;
            drain();
        end

        write_reg(hdr_pkg::REG_SHORT_GAIN, 24'd262144);
        write_reg(hdr_pkg::REG_LONG_GAIN, 24'd16384);
        write_reg(hdr_pkg::REG_SAT_THR, 24'd62259);
        write_reg(hdr_pkg::REG_UNDER_THR, 24'd3277);
        write_reg(hdr_pkg::REG_FLOOR, 24'd1);
        burst(300);
        drain();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/hdr_pkg.sv
hw/rtl/hdr_div_cell.sv
hw/rtl/hdr_div_chain.sv
hw/rtl/two_exposure_hdr_pixel_merge_unit.sv
tb/testbench.sv
